FILE: rtl/core/trvm_pkg.sv
// Shared types and constants for the ten-register stack machine executor.
// Used by trvm_exec and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package trvm_pkg;

    localparam int NUM_REGS   = 10;
    localparam int REG_IDX_W  = 4;
    // power of two: jump targets wrap to the low address bits
    localparam int PROG_DEPTH = 1024;

    localparam logic [3:0] OP_PUSH = 4'd0;
    localparam logic [3:0] OP_INTR = 4'd1;
    localparam logic [3:0] OP_POP  = 4'd2;
    localparam logic [3:0] OP_HALT = 4'd3;
    localparam logic [3:0] OP_MOVE = 4'd4;
    localparam logic [3:0] OP_INC  = 4'd5;
    localparam logic [3:0] OP_DEC  = 4'd6;
    localparam logic [3:0] OP_JMP  = 4'd7;
    localparam logic [3:0] OP_SKIP = 4'd8;
    localparam logic [3:0] OP_JLE  = 4'd9;
    localparam logic [3:0] OP_JGT  = 4'd10;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_HALT = 2'd1,
        ST_TRAP = 2'd2
    } run_state_t;

    typedef struct packed {
        logic                 reg_we;
        logic                 pop_we;
        logic [REG_IDX_W-1:0] slot;
        logic                 push_en;
        logic                 pop_en;
        logic                 char_valid;
        run_state_t           status;
    } exec_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/trvm_stack.sv
// Push-down store: single write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module trvm_stack #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int AW         = $clog2(STACK_DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/trvm_exec.sv
// Single-instruction execute logic: decode, operand select, next state.
// Depends on trvm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trvm_exec #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int SP_W       = $clog2(STACK_DEPTH + 1),
    localparam int IP_W       = $clog2(trvm_pkg::PROG_DEPTH)
) (
    input  wire logic [3:0]                                   operation,
    input  wire logic signed [31:0]                           dest_operand,
    input  wire logic signed [31:0]                           src_operand,
    input  wire logic [trvm_pkg::NUM_REGS-1:0][DATA_WIDTH-1:0] regs,
    input  wire logic [SP_W-1:0]                              sp,
    input  wire logic [IP_W-1:0]                              ip,
    input  wire trvm_pkg::run_state_t                         status,
    output trvm_pkg::exec_ctl_t                               ctl,
    output logic [DATA_WIDTH-1:0]                             wdata,
    output logic [DATA_WIDTH-1:0]                             push_data,
    output logic [SP_W-1:0]                                   sp_next,
    output logic [IP_W-1:0]                                   ip_next,
    output logic [7:0]                                        char_byte
);

    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
    localparam logic [IP_W-1:0] IP_LAST = IP_W'(trvm_pkg::PROG_DEPTH - 1);

    logic                            d_ok, s_ok, le_zero, take;
    logic [trvm_pkg::REG_IDX_W-1:0]  d_slot, s_slot;
    logic [DATA_WIDTH-1:0]           d_val, s_val;
    logic [IP_W-1:0]                 ip_adv, ip_tgt;

    assign d_ok   = (dest_operand >= 32'sd1) &&
                    (dest_operand <= 32'(trvm_pkg::NUM_REGS));
    assign s_ok   = (src_operand >= 32'sd1) &&
                    (src_operand <= 32'(trvm_pkg::NUM_REGS));
    assign d_slot = dest_operand[trvm_pkg::REG_IDX_W-1:0] - 1'b1;
    assign s_slot = src_operand[trvm_pkg::REG_IDX_W-1:0] - 1'b1;
    assign d_val  = d_ok ? regs[d_slot] : '0;
    assign s_val  = s_ok ? regs[s_slot] : '0;

    assign le_zero   = (s_val == '0) || s_val[DATA_WIDTH-1];
    assign take      = (operation == trvm_pkg::OP_JLE) == le_zero;
    assign ip_adv    = (ip == IP_LAST) ? '0 : ip + 1'b1;
    // program depth is a power of two: target wraps to the low bits
    assign ip_tgt    = dest_operand[IP_W-1:0];
    assign push_data = DATA_WIDTH'(dest_operand);

    always_comb begin
        ctl        = '0;
        ctl.status = status;
        ctl.slot   = d_slot;
        wdata      = '0;
        sp_next    = sp;
        ip_next    = ip;
        char_byte  = '0;
        if (status == trvm_pkg::ST_RUN) begin
            unique case (operation)
                trvm_pkg::OP_PUSH: begin
                    if (sp >= SP_FULL) begin
                        ctl.status = trvm_pkg::ST_TRAP;
                    end else begin
                        ctl.push_en = 1'b1;
                        sp_next     = sp + 1'b1;
                        ip_next     = ip_adv;
                    end
                end
                trvm_pkg::OP_INTR: begin
                    if (dest_operand != '0 || !s_ok) begin
                        ctl.status = trvm_pkg::ST_TRAP;
                    end else begin
                        ctl.char_valid = 1'b1;
                        char_byte      = s_val[7:0];
                    end
                    ip_next = ip_adv;
                end
                trvm_pkg::OP_POP: begin
                    if (sp == '0 || sp > SP_FULL) begin
                        ctl.status = trvm_pkg::ST_TRAP;
                    end else begin
                        ctl.pop_en = 1'b1;
                        ctl.pop_we = d_ok;
                        sp_next    = sp - 1'b1;
                        ip_next    = ip_adv;
                    end
                end
                trvm_pkg::OP_HALT: begin
                    ctl.status = trvm_pkg::ST_HALT;
                    ip_next    = ip_adv;
                end
                trvm_pkg::OP_MOVE: begin
                    ctl.reg_we = d_ok;
                    wdata      = DATA_WIDTH'(src_operand);
                    ip_next    = ip_adv;
                end
                trvm_pkg::OP_INC, trvm_pkg::OP_DEC: begin
                    if (!d_ok) begin
                        ctl.status = trvm_pkg::ST_TRAP;
                    end else begin
                        ctl.reg_we = 1'b1;
                        wdata      = (operation == trvm_pkg::OP_INC) ? d_val + 1'b1
                                                                      : d_val - 1'b1;
                    end
                    ip_next = ip_adv;
                end
                trvm_pkg::OP_JMP: begin
                    ip_next = ip_tgt;
                end
                trvm_pkg::OP_SKIP: begin
                    ip_next = ip_adv;
                end
                trvm_pkg::OP_JLE, trvm_pkg::OP_JGT: begin
                    if (!s_ok) begin
                        ctl.status = trvm_pkg::ST_TRAP;
                    end
                    ip_next = take ? ip_tgt : ip_adv;
                end
                default: begin
                    ctl.status = trvm_pkg::ST_TRAP;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ten_register_stack_vm_executor_top.sv
// Results of accepted items are registered in the output register. Throughput:
// one item per cycle when the output is not stalled; a pop's stack read lands in
// its register in the cycle after the pop, with forwarding to the following item.
// Reset (aresetn low, synchronous): registers, stack and instruction pointers
// cleared, status running; stack contents are not cleared.
// Depends on trvm_pkg, trvm_exec, trvm_stack.
`timescale 1ns / 1ps
`default_nettype none
module ten_register_stack_vm_executor_top #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int IP_W       = $clog2(trvm_pkg::PROG_DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_operation,
    input  wire logic signed [31:0] s_dest_operand,
    input  wire logic signed [31:0] s_src_operand,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [IP_W-1:0]         m_next_ip,
    output logic [1:0]              m_run_state,
    output logic                    m_char_valid,
    output logic [7:0]              m_char_byte
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int NR   = trvm_pkg::NUM_REGS;

    logic [NR-1:0][DATA_WIDTH-1:0] regs_reg, regs_next, eff_regs;
    logic [SP_W-1:0]               sp_reg, sp_next, ex_sp;
    logic [IP_W-1:0]               ip_reg, ip_next, ex_ip;
    trvm_pkg::run_state_t          status_reg, status_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [trvm_pkg::REG_IDX_W-1:0] pend_slot_reg, pend_slot_next;
    logic                          m_valid_reg, m_valid_next;
    logic [IP_W-1:0]               m_ip_reg;
    trvm_pkg::run_state_t          m_state_reg;
    logic                          m_cv_reg;
    logic [7:0]                    m_cb_reg;

    trvm_pkg::exec_ctl_t           ctl;
    logic [DATA_WIDTH-1:0]         wdata, push_data, mem_rdata;
    logic [7:0]                    char_byte;
    logic [SP_W-1:0]               sp_dec;
    logic                          accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign sp_dec  = sp_reg - 1'b1;

    always_comb begin
        for (int i = 0; i < NR; i++) begin
            eff_regs[i] = (pend_valid_reg && pend_slot_reg == trvm_pkg::REG_IDX_W'(i))
                          ? mem_rdata : regs_reg[i];
        end
    end

    trvm_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_exec (
        .operation    (s_operation),
        .dest_operand (s_dest_operand),
        .src_operand  (s_src_operand),
        .regs         (eff_regs),
        .sp           (sp_reg),
        .ip           (ip_reg),
        .status       (status_reg),
        .ctl          (ctl),
        .wdata        (wdata),
        .push_data    (push_data),
        .sp_next      (ex_sp),
        .ip_next      (ex_ip),
        .char_byte    (char_byte)
    );

    trvm_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (accept && ctl.push_en),
        .wr_addr (sp_reg[AW-1:0]),
        .wr_data (push_data),
        .rd_en   (accept && ctl.pop_en),
        .rd_addr (sp_dec[AW-1:0]),
        .rd_data (mem_rdata)
    );

    always_comb begin
        regs_next       = eff_regs;
        sp_next         = sp_reg;
        ip_next         = ip_reg;
        status_next     = status_reg;
        pend_valid_next = 1'b0;
        pend_slot_next  = pend_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if (accept) begin
            if (ctl.reg_we) begin
                regs_next[ctl.slot] = wdata;
            end
            sp_next         = ex_sp;
            ip_next         = ex_ip;
            status_next     = ctl.status;
            pend_valid_next = ctl.pop_we;
            pend_slot_next  = ctl.slot;
            m_valid_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg       <= '0;
            sp_reg         <= '0;
            ip_reg         <= '0;
            status_reg     <= trvm_pkg::ST_RUN;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            regs_reg       <= regs_next;
            sp_reg         <= sp_next;
            ip_reg         <= ip_next;
            status_reg     <= status_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_slot_reg <= pend_slot_next;
        if (accept) begin
            m_ip_reg    <= ex_ip;
            m_state_reg <= ctl.status;
            m_cv_reg    <= ctl.char_valid;
            m_cb_reg    <= char_byte;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_next_ip    = m_ip_reg;
    assign m_run_state  = m_state_reg;
    assign m_char_valid = m_cv_reg;
    assign m_char_byte  = m_cb_reg;

    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_status_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg != trvm_pkg::ST_RUN) |=> (status_reg == $past(status_reg)))
        else $error("status left halted/trapped");

    a_pend_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> $past(accept && ctl.pop_en))
        else $error("pending register write without a pop");

    a_char_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_cv_reg) |-> (m_state_reg == trvm_pkg::ST_RUN))
        else $error("character emitted while not running");

endmodule
`default_nettype wire

FILE: test/ten_register_stack_vm_executor_top_tb.sv
// Self-checking testbench for ten_register_stack_vm_executor_top: a directed program,
// then random running-safe instructions and one stopping case, all checked against a predictor.
// Depends on trvm_pkg and the executor RTL.
`timescale 1ns / 1ps
module ten_register_stack_vm_executor_top_tb;
    import trvm_pkg::*;

    localparam int STACK_DEPTH     = 256;
    localparam int PROG_DEPTH      = 1024;
    localparam int DATA_WIDTH      = 32;
    localparam int IP_W            = $clog2(PROG_DEPTH);
    localparam int RANDOM_ITEMS    = 1500;
    localparam int PHASES          = 8;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int TRAILING_ITEMS  = 20;

    localparam logic [3:0]  OP_UNKNOWN_LO = 4'd11;
    localparam logic [3:0]  OP_UNKNOWN_HI = 4'd15;
    localparam logic [31:0] CHAR_INTR     = 32'd0;

    typedef enum int {
        STOP_UNKNOWN_OP,
        STOP_PUSH_FULL,
        STOP_POP_EMPTY,
        STOP_BAD_INCDEC,
        STOP_BAD_INTR,
        STOP_INTR_BAD_SRC,
        STOP_COND_BAD_SRC,
        STOP_HALT
    } stop_kind_t;

    typedef struct packed {
        logic [IP_W-1:0] ip;
        run_state_t      state;
        logic            char_valid;
        logic [7:0]      char_byte;
    } step_result_t;

    typedef struct {
        logic [3:0]   op;
        logic [31:0]  dst;
        logic [31:0]  src;
        bit           typed;
        step_result_t res;
    } program_row_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [3:0]              s_operation    = '0;
    logic signed [31:0]      s_dest_operand = '0;
    logic signed [31:0]      s_src_operand  = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [IP_W-1:0]         m_next_ip;
    logic [1:0]              m_run_state;
    logic                    m_char_valid;
    logic [7:0]              m_char_byte;

    // executor state as predicted
    logic [DATA_WIDTH-1:0] vm_regs [NUM_REGS];
    logic [DATA_WIDTH-1:0] vm_stack [STACK_DEPTH];
    int                    vm_sp;
    logic [IP_W-1:0]       vm_ip;
    run_state_t            vm_state;

    step_result_t expected_results[$];
    step_result_t want;
    int           mismatches   = 0;
    int           stuck_cycles = 0;
    int           tx_idle_pct  = 0;
    int           rx_stall_pct = 0;
    bit           hold_off_req = 1'b0;

    program_row_t directed_rows[25] = '{
        '{OP_MOVE, 32'd1,          32'h7FFF_FFFF, 1'b1, '{10'd1,    ST_RUN, 1'b0, 8'h00}},
        '{OP_MOVE, 32'd2,          32'h8000_0000, 1'b0, '0},
        '{OP_INC,  32'd1,          32'd0,         1'b0, '0},
        '{OP_DEC,  32'd2,          32'd0,         1'b0, '0},
        '{OP_INTR, CHAR_INTR,      32'd1,         1'b1, '{10'd5,    ST_RUN, 1'b1, 8'h00}},
        '{OP_MOVE, 32'd3,          32'hFFFF_FFFF, 1'b0, '0},
        '{OP_INTR, CHAR_INTR,      32'd3,         1'b1, '{10'd7,    ST_RUN, 1'b1, 8'hFF}},
        '{OP_PUSH, 32'h8000_0000,  32'd0,         1'b0, '0},
        '{OP_PUSH, 32'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b0, '0},
        '{OP_POP,  32'd10,         32'd0,         1'b0, '0},
        '{OP_POP,  32'd0,          32'd0,         1'b0, '0},
        '{OP_MOVE, 32'hFFFF_FFFF,  32'd5,         1'b0, '0},
        '{OP_MOVE, 32'd11,         32'd0,         1'b0, '0},
        '{OP_JLE,  32'h7FFF_FFFF,  32'd1,         1'b0, '0},
        '{OP_SKIP, 32'd0,          32'd0,         1'b1, '{10'd0,    ST_RUN, 1'b0, 8'h00}},
        '{OP_JGT,  32'hFFFF_FFFE,  32'd10,        1'b0, '0},
        '{OP_JGT,  32'd5,          32'd4,         1'b0, '0},
        '{OP_JLE,  32'd500,        32'd4,         1'b0, '0},
        '{OP_JMP,  32'hFFFF_FFFF,  32'd0,         1'b1, '{10'd1023, ST_RUN, 1'b0, 8'h00}},
        '{OP_JMP,  32'h8000_0000,  32'd0,         1'b1, '{10'd0,    ST_RUN, 1'b0, 8'h00}},
        '{OP_INC,  32'd10,         32'd0,         1'b0, '0},
        '{OP_DEC,  32'd4,          32'd0,         1'b0, '0},
        '{OP_JGT,  32'd100,        32'd4,         1'b0, '0},
        '{OP_MOVE, 32'd5,          32'h55AA_00FF, 1'b0, '0},
        '{OP_INTR, CHAR_INTR,      32'd5,         1'b0, '0}
    };

    ten_register_stack_vm_executor_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_dest_operand (s_dest_operand),
        .s_src_operand  (s_src_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_ip      (m_next_ip),
        .m_run_state    (m_run_state),
        .m_char_valid   (m_char_valid),
        .m_char_byte    (m_char_byte)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int reg_slot(logic [31:0] raw);
        if (raw >= 32'd1 && raw <= NUM_REGS) begin
            return int'(raw) - 1;
        end
        return -1;
    endfunction

    // executes one instruction on the predicted state, returns its result
    function automatic step_result_t execute_instr(logic [3:0] op, logic [31:0] dst,
                                                   logic [31:0] src);
        step_result_t          r;
        int                    d;
        int                    s;
        logic [DATA_WIDTH-1:0] rv;
        d = reg_slot(dst);
        s = reg_slot(src);
        r = '0;
        if (vm_state == ST_RUN) begin
            case (op)
                OP_PUSH: begin
                    if (vm_sp >= STACK_DEPTH) begin
                        vm_state = ST_TRAP;
                    end else begin
                        vm_stack[vm_sp] = dst;
                        vm_sp++;
                        vm_ip++;
                    end
                end
                OP_INTR: begin
                    if (dst != CHAR_INTR || s < 0) begin
                        vm_state = ST_TRAP;
                    end else begin
                        r.char_valid = 1'b1;
                        r.char_byte  = vm_regs[s][7:0];
                    end
                    vm_ip++;
                end
                OP_POP: begin
                    if (vm_sp == 0) begin
                        vm_state = ST_TRAP;
                    end else begin
                        vm_sp--;
                        if (d >= 0) vm_regs[d] = vm_stack[vm_sp];
                        vm_ip++;
                    end
                end
                OP_HALT: begin
                    vm_state = ST_HALT;
                    vm_ip++;
                end
                OP_MOVE: begin
                    if (d >= 0) vm_regs[d] = src;
                    vm_ip++;
                end
                OP_INC, OP_DEC: begin
                    if (d < 0) vm_state = ST_TRAP;
                    else if (op == OP_INC) vm_regs[d] = vm_regs[d] + 1'b1;
                    else vm_regs[d] = vm_regs[d] - 1'b1;
                    vm_ip++;
                end
                OP_JMP: vm_ip = dst[IP_W-1:0];
                OP_SKIP: vm_ip++;
                OP_JLE, OP_JGT: begin
                    rv = '0;
                    if (s < 0) vm_state = ST_TRAP;
                    else rv = vm_regs[s];
                    if ((op == OP_JLE) == (rv == '0 || rv[DATA_WIDTH-1])) vm_ip = dst[IP_W-1:0];
                    else vm_ip++;
                end
                default: vm_state = ST_TRAP;
            endcase
        end
        r.ip    = vm_ip;
        r.state = vm_state;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(6))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_reg();
        return $urandom_range(NUM_REGS, 1);
    endfunction

    function automatic logic [31:0] bad_reg();
        case ($urandom_range(2))
            0: return 32'd0;
            1: return NUM_REGS + 1;
            default: return $urandom | 32'h8000_0000;
        endcase
    endfunction

    task automatic send_instr(logic [3:0] op, logic [31:0] dst, logic [31:0] src,
                              bit typed = 1'b0, step_result_t typed_res = '0);
        step_result_t r;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_dest_operand <= dst;
        s_src_operand  <= src;
        do @(posedge aclk); while (!s_ready);
        r = execute_instr(op, dst, src);
        expected_results.push_back(typed ? typed_res : r);
    endtask

    // well-formed instructions only: the machine keeps running
    task automatic send_running_instr();
        int pick;
        pick = $urandom_range(99);
        if (pick < 17 && vm_sp >= STACK_DEPTH) pick = 20;
        if (pick >= 17 && pick < 30 && vm_sp == 0) pick = 0;
        if (pick < 17) begin
            send_instr(OP_PUSH, rand_word(), rand_word());
        end else if (pick < 30) begin
            send_instr(OP_POP, ($urandom_range(99) < 85) ? rand_reg() : rand_word(), rand_word());
        end else if (pick < 45) begin
            send_instr(OP_MOVE, ($urandom_range(99) < 85) ? rand_reg() : rand_word(), rand_word());
        end else if (pick < 55) begin
            send_instr(OP_INC, rand_reg(), rand_word());
        end else if (pick < 65) begin
            send_instr(OP_DEC, rand_reg(), rand_word());
        end else if (pick < 73) begin
            send_instr(OP_INTR, CHAR_INTR, rand_reg());
        end else if (pick < 81) begin
            send_instr(OP_JMP, rand_word(), rand_word());
        end else if (pick < 87) begin
            send_instr(OP_SKIP, rand_word(), rand_word());
        end else if (pick < 94) begin
            send_instr(OP_JLE, rand_word(), rand_reg());
        end else begin
            send_instr(OP_JGT, rand_word(), rand_reg());
        end
    endtask

    // drives the machine out of the running state by one of the stopping cases
    task automatic send_stop_case();
        stop_kind_t  kind;
        logic [31:0] intr_num;
        kind = stop_kind_t'($urandom_range(STOP_HALT));
        case (kind)
            STOP_UNKNOWN_OP:
                send_instr(4'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO)), rand_word(),
                           rand_word());
            STOP_PUSH_FULL: begin
                while (vm_sp < STACK_DEPTH) send_instr(OP_PUSH, rand_word(), rand_word());
                send_instr(OP_PUSH, rand_word(), rand_word());
            end
            STOP_POP_EMPTY: begin
                while (vm_sp > 0) send_instr(OP_POP, rand_reg(), rand_word());
                send_instr(OP_POP, rand_reg(), rand_word());
            end
            STOP_BAD_INCDEC:
                send_instr($urandom_range(1) ? OP_INC : OP_DEC, bad_reg(), rand_word());
            STOP_BAD_INTR: begin
                intr_num = rand_word();
                if (intr_num == CHAR_INTR) intr_num = 32'd1;
                send_instr(OP_INTR, intr_num, rand_reg());
            end
            STOP_INTR_BAD_SRC:
                send_instr(OP_INTR, CHAR_INTR, bad_reg());
            STOP_COND_BAD_SRC:
                send_instr($urandom_range(1) ? OP_JLE : OP_JGT, rand_word(), bad_reg());
            default:
                send_instr(OP_HALT, rand_word(), rand_word());
        endcase
    endtask

    initial begin
        foreach (vm_regs[i]) vm_regs[i] = '0;
        vm_sp    = 0;
        vm_ip    = '0;
        vm_state = ST_RUN;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_instr(directed_rows[i].op, directed_rows[i].dst, directed_rows[i].src,
                       directed_rows[i].typed, directed_rows[i].res);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            if (phase % 4 == 0) hold_off_req = 1'b1;
            repeat (RANDOM_ITEMS / PHASES) send_running_instr();
        end

        tx_idle_pct  = 33;
        rx_stall_pct = 33;
        send_stop_case();
        // nothing may change once stopped
        repeat (TRAILING_ITEMS) send_instr(4'($urandom_range(OP_UNKNOWN_HI)), $urandom, $urandom);
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item ip=%0d state=%0d char=%0b/%02h",
                                m_next_ip, m_run_state, m_char_valid, m_char_byte));
            end else begin
                want = expected_results.pop_front();
                if (m_next_ip !== want.ip || m_run_state !== want.state ||
                    m_char_valid !== want.char_valid || m_char_byte !== want.char_byte) begin
                    report_mismatch($sformatf(
                        "expected ip=%0d state=%0d char=%0b/%02h, got ip=%0d state=%0d char=%0b/%02h",
                        want.ip, want.state, want.char_valid, want.char_byte,
                        m_next_ip, m_run_state, m_char_valid, m_char_byte));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule

FILE: files.f
rtl/core/trvm_pkg.sv
rtl/core/trvm_stack.sv
rtl/core/trvm_exec.sv
rtl/core/ten_register_stack_vm_executor_top.sv
test/ten_register_stack_vm_executor_top_tb.sv
